// File: sv/hms_pkg.sv
package hms_pkg;

   // store geometry
   localparam int BINS  = 1024;
   localparam int IDX_W = $clog2(BINS);

   // item field widths
   localparam int FUNC_W   = 1;
   localparam int KEY_W    = 10;
   localparam int COUNT_W  = 32;
   localparam int BIN_W    = 32;
   localparam int MEDIAN_W = 10;
   localparam int TOTAL_W  = 52;
   localparam int POINTS_W = 42;
   localparam int MEAN_W   = 18;
   localparam int FRAC_W   = 8;

   // stream packing
   localparam int REQ_FIELDS_W = KEY_W + COUNT_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = BIN_W + MEDIAN_W + TOTAL_W + POINTS_W + MEAN_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // datapath widths
   localparam int PROD_W = IDX_W + BIN_W;
   localparam int DVD_W  = TOTAL_W + FRAC_W;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic                start;
      logic [TOTAL_W-1:0]  total;
      logic [POINTS_W-1:0] points;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [MEAN_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: sv/histogram_median_stats.sv
// Histogram statistics over a store of BINS 32-bit bin counts held in one
// single-port-write, registered-read RAM. An add item (tuser = 0) adds its
// count to bin key, saturating at all ones, and returns the new bin value
// after the RAM read (ADD_RD) and the saturating add and write-back
// (ADD_WR), which waits while the output register is full. A query item
// (tuser = 1) returns the median key, weighted total, point count, mean
// key with 8 fraction bits and an empty flag. A query runs one RAM sweep
// feeding a registered 10x32 multiplier and two accumulators, a second
// sweep that walks the running count up to half the points (it stops at
// the median bin), then an 18-step restoring divider, and then loads the
// result once the output register is free. An empty store skips the
// second sweep and the divider. The RAM port is the limit: one bin read
// per cycle.
// One item is in work at a time; req_tready is high only when the block
// is idle. A finished result sits in an output register, so the next item
// can be taken while it waits. After reset the block zeroes every bin of
// the store and accepts no item until that pass is done.
module histogram_median_stats (
   input  logic                                clock,
   input  logic                                reset,
   // req item
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] key, [41:10] count, rest zero
   input  logic [hms_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] func
   input  logic [hms_pkg::FUNC_W-1:0]          req_tuser,
   // rsp item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] bin_value, [41:32] median_key, [93:42] weighted_total,
   // [135:94] point_count, [153:136] mean_fixed, rest zero
   output logic [hms_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] is_empty
   output logic                                rsp_tuser
);
   import hms_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BINS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_SUM,
      ST_SUM_WAIT,
      ST_MED,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // sequencer and request holding
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  key_ok_ff, key_ok_in;

   // sweep pipeline: stage 1 = RAM data, stage 2 = product
   logic                  s1_ff, s1_in;
   logic [IDX_W-1:0]      s1_key_ff, s1_key_in;
   logic                  s2_ff, s2_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [BIN_W-1:0]      cnt2_ff, cnt2_in;

   // statistics
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [POINTS_W-1:0]   points_ff, points_in;
   logic [POINTS_W-1:0]   cum_ff, cum_in;
   logic [POINTS_W-1:0]   half_ff, half_in;
   logic [MEDIAN_W-1:0]   median_ff, median_in;
   logic [MEAN_W-1:0]     mean_ff, mean_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   // RAM port
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [BIN_W-1:0]      wr_data;
   logic [BIN_W-1:0]      rd_data;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  out_free;
   logic [BIN_W:0]        sat_sum;
   logic [BIN_W-1:0]      bin_new;
   logic [POINTS_W:0]     cum_next;
   logic                  med_hit;
   logic [KEY_W-1:0]      req_key;
   logic [COUNT_W-1:0]    req_count;

   hms_ram #(
      .WIDTH (BIN_W),
      .DEPTH (BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   hms_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_key   = req_tdata[KEY_W-1:0];
   assign req_count = req_tdata[KEY_W +: COUNT_W];

   assign out_free = !rsp_valid_ff || rsp_tready;

   // saturating add for the add item
   assign sat_sum = {1'b0, rd_data} + {1'b0, count_ff};
   assign bin_new = sat_sum[BIN_W] ? {BIN_W{1'b1}} : sat_sum[BIN_W-1:0];

   // median: first bin whose running count passes half the points
   assign cum_next = {1'b0, cum_ff} + (POINTS_W + 1)'(rd_data);
   assign med_hit  = (cum_next > {1'b0, half_ff});

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      key_ok_in    = key_ok_ff;
      s1_in        = 1'b0;
      s1_key_in    = addr_ff;
      s2_in        = s1_ff && (state_ff == ST_SUM || state_ff == ST_SUM_WAIT);
      prod_in      = PROD_W'(s1_key_ff) * PROD_W'(rd_data);
      cnt2_in      = rd_data;
      total_in     = total_ff;
      points_in    = points_ff;
      cum_in       = cum_ff;
      half_in      = half_ff;
      median_in    = median_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      div_req.start  = 1'b0;
      div_req.total  = total_ff;
      div_req.points = points_ff;
      req_tready   = (state_ff == ST_IDLE);

      if (s2_ff) begin
         total_in  = total_ff + TOTAL_W'(prod_ff);
         points_in = points_ff + POINTS_W'(cnt2_ff);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               count_in = req_count;
               if (req_tuser == FUNC_ADD) begin
                  addr_in   = IDX_W'(req_key);
                  key_ok_in = (32'(req_key) < 32'(BINS));
                  state_in  = ST_ADD_RD;
               end else begin
                  addr_in   = '0;
                  total_in  = '0;
                  points_in = '0;
                  state_in  = ST_SUM;
               end
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            if (out_free) begin
               wr_en        = key_ok_ff;
               wr_data      = bin_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'(key_ok_ff ? bin_new : '0);
               rsp_empty_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_SUM: begin
            s1_in = 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_SUM_WAIT;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_SUM_WAIT: begin
            if (!s1_ff && !s2_ff) begin
               half_in   = points_ff >> 1;
               cum_in    = '0;
               addr_in   = '0;
               median_in = '0;
               mean_in   = '0;
               state_in  = (points_ff == '0) ? ST_FIN : ST_MED;
            end
         end
         ST_MED: begin
            s1_in = 1'b1;
            if (addr_ff != LAST_IDX) begin
               addr_in = addr_ff + 1'b1;
            end
            if (s1_ff) begin
               cum_in = cum_next[POINTS_W-1:0];
               if (med_hit) begin
                  median_in = MEDIAN_W'(s1_key_ff);
                  state_in  = ST_DIV_GO;
               end else if (s1_key_ff == LAST_IDX) begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quot;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({mean_ff, points_ff, total_ff, median_ff,
                                           {BIN_W{1'b0}}});
               rsp_empty_in = (points_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff     <= count_in;
      key_ok_ff    <= key_ok_in;
      s1_key_ff    <= s1_key_in;
      prod_ff      <= prod_in;
      cnt2_ff      <= cnt2_in;
      total_ff     <= total_in;
      points_ff    <= points_in;
      cum_ff       <= cum_in;
      half_ff      <= half_in;
      median_ff    <= median_in;
      mean_ff      <= mean_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // no item taken while the store is being zeroed
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("item accepted during clear pass");

   // divider only finishes while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done outside divide wait");

   // product stage never active during median walk
   a_med_no_accum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MED) |-> !s2_ff)
      else $error("accumulator active during median walk");

   // an empty query reports zero in every field of the held result
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_data_ff == '0))
      else $error("empty result with nonzero statistics");

endmodule

// File: sv/hms_ram.sv
module hms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hms_div.sv
module hms_div (
   input  logic                clock,
   input  logic                reset,
   input  hms_pkg::div_req_type div_req,
   output hms_pkg::div_rsp_type div_rsp
);
   import hms_pkg::*;

   localparam int CNT_W = $clog2(MEAN_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MEAN_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POINTS_W-1:0] rem_ff, rem_in;
   logic [POINTS_W-1:0] divisor_ff, divisor_in;
   logic [MEAN_W-1:0]   dvd_ff, dvd_in;
   logic [MEAN_W-1:0]   quot_ff, quot_in;

   logic [DVD_W-1:0]    dividend;
   logic [POINTS_W:0]   trial;
   logic [POINTS_W:0]   diff;
   logic                ge;

   // dividend = total << FRAC_W; quotient always fits MEAN_W bits,
   // so the upper part starts out below the divisor
   assign dividend = {div_req.total, {FRAC_W{1'b0}}};
   assign trial    = {rem_ff, dvd_ff[MEAN_W-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign ge       = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      dvd_in     = dvd_ff;
      quot_in    = quot_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = dividend[DVD_W-1:MEAN_W];
         dvd_in     = dividend[MEAN_W-1:0];
         divisor_in = div_req.points;
         quot_in    = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[POINTS_W-1:0] : trial[POINTS_W-1:0];
         dvd_in  = {dvd_ff[MEAN_W-2:0], 1'b0};
         quot_in = {quot_ff[MEAN_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dvd_ff     <= dvd_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule
